[sv/mlqd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqd_pkg
// Shared types, widths and constants of the multilevel queue dispatcher.
// ----------------------------------------------------------------------------
package mlqd_pkg;

	// Fixed field widths
	localparam int PRIO_W  = 4;
	localparam int PID_W   = 8;
	localparam int PC_W    = 32;
	localparam int QUANT_W = 8;

	// Parameter defaults
	localparam int LEVELS_DEF      = 15;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int PID_BITS_DEF    = 8;

	// Stream widths: 45 and 50 payload bits padded to whole bytes
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	// Command queue between front and back
	localparam int CMD_FIFO_DEPTH = 2;

	localparam logic [QUANT_W-1:0] IDLE_QUANTUM_RST = 8'd2;

	// Item kinds carried on tuser
	localparam logic FUNC_NEW_JOB = 1'b0;
	localparam logic FUNC_TIMER   = 1'b1;

	// Classified item handed from front to back
	typedef struct packed {
		logic              timer;
		logic [PRIO_W-1:0] level;
		logic [PID_W-1:0]  pid;
		logic              halted;
		logic [PC_W-1:0]   pc;
	} cmd_t;

	// Result item
	typedef struct packed {
		logic [PID_W-1:0]   run_pid;
		logic               run_is_idle;
		logic [PC_W-1:0]    run_pc;
		logic [QUANT_W-1:0] quantum;
		logic               queue_full;
	} res_t;

	// Slice length of a level: level squared
	function automatic logic [QUANT_W-1:0] level_square(input logic [PRIO_W-1:0] lvl);
		logic [2*PRIO_W-1:0] sq;
		sq = lvl * lvl;
		return QUANT_W'(sq);
	endfunction

endpackage

[sv/mlqd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/mlqd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqd_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module mlqd_front import mlqd_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                  s_axis_tuser,
	output cmd_t                  cmd,
	output logic                  cmd_valid,
	input  logic                  cmd_ready
);

	localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t             fifo_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	cmd_t             in_cmd;
	logic [PRIO_W-1:0] prio;
	logic             push;
	logic             pop;

	// Classify: decode kind, saturate priority to the top level
	always_comb begin
		prio          = s_axis_tdata[11:8];
		in_cmd.timer  = (s_axis_tuser == FUNC_TIMER);
		in_cmd.level  = ({1'b0, prio} >= (PRIO_W + 1)'(LEVELS)) ? PRIO_W'(LEVELS - 1) : prio;
		in_cmd.pid    = s_axis_tdata[7:0];
		in_cmd.halted = s_axis_tdata[12];
		in_cmd.pc     = s_axis_tdata[44:13];
	end

	assign s_axis_tready = (cnt_q != CNT_W'(CMD_FIFO_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (cnt_q != '0);
	assign pop           = cmd_valid && cmd_ready;
	assign cmd           = fifo_q[rd_ptr_q];

	// Store classified items
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/mlqd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqd_back
// Executes classified items: enqueue, requeue, dispatch and result output.
// ----------------------------------------------------------------------------
module mlqd_back import mlqd_pkg::*; #(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int PID_BITS    = PID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic               cfg_valid,
	input  logic [QUANT_W-1:0] cfg_data,
	output res_t               res,
	output logic               res_valid,
	input  logic               res_ready
);

	localparam int LVL_W     = $clog2(LEVELS);
	localparam int IDX_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W    = LVL_W + IDX_W;
	localparam int RAM_DEPTH = LEVELS * (2 ** IDX_W);
	localparam int DATA_W    = PC_W + PID_BITS;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SEL  = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    head_q  [LEVELS];
	logic [IDX_W-1:0]    tail_q  [LEVELS];
	logic [CNT_W-1:0]    count_q [LEVELS];
	logic                run_valid_q;
	logic [PID_BITS-1:0] run_pid_q;
	logic [LVL_W-1:0]    run_lvl_q;
	logic [QUANT_W-1:0]  idle_quantum_q;
	logic                full_q;
	logic                disp_q;
	res_t                res_q;
	logic                res_valid_q;

	logic                fire;
	logic [LVL_W:0]      next_lvl;
	logic [LVL_W-1:0]    push_lvl;
	logic                push_req;
	logic [PID_BITS-1:0] push_pid;
	logic [PC_W-1:0]     push_pc;
	logic [LEVELS-1:0]   full_vec;
	logic [LEVELS-1:0]   busy_vec;
	logic                lvl_full;
	logic                do_push;
	logic                any_ready;
	logic [LVL_W-1:0]    sel_lvl;
	logic                do_pop;
	logic [DATA_W-1:0]   wdata;
	logic [DATA_W-1:0]   rdata;
	logic [PID_BITS-1:0] rd_pid;
	logic [PC_W-1:0]     rd_pc;
	logic [PID_BITS-1:0] out_pid;
	logic [PID_BITS+PID_W-1:0] out_pid_ext;
	logic                res_load;

	// Per-level status seen at fixed places
	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			full_vec[i] = (count_q[i] == CNT_W'(QUEUE_DEPTH));
			busy_vec[i] = (count_q[i] != '0);
		end
	end

	// Pick the lowest nonempty level
	always_comb begin
		sel_lvl   = '0;
		any_ready = |busy_vec;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (busy_vec[i]) begin
				sel_lvl = LVL_W'(i);
			end
		end
	end

	// Enqueue target: arriving job, or running job one level down with wrap
	always_comb begin
		next_lvl = {1'b0, run_lvl_q} + 1'b1;
		if (cmd.timer) begin
			push_lvl = (next_lvl >= (LVL_W + 1)'(LEVELS)) ? '0 : next_lvl[LVL_W-1:0];
			push_req = run_valid_q && !cmd.halted;
			push_pid = run_pid_q;
			push_pc  = cmd.pc;
		end else begin
			push_lvl = cmd.level[LVL_W-1:0];
			push_req = 1'b1;
			push_pid = PID_BITS'(cmd.pid);
			push_pc  = '0;
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign fire      = cmd_ready && cmd_valid;
	assign lvl_full  = full_vec[push_lvl];
	assign do_push   = fire && push_req && !lvl_full;
	assign do_pop    = (state_q == ST_SEL) && any_ready;
	assign wdata     = {push_pc, push_pid};
	assign rd_pid    = rdata[PID_BITS-1:0];
	assign rd_pc     = rdata[DATA_W-1:PID_BITS];
	assign res_load  = (state_q == ST_RESP) && (!res_valid_q || res_ready);

	mlqd_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr ({push_lvl, tail_q[push_lvl]}),
		.wdata (wdata),
		.re    (do_pop),
		.raddr ({sel_lvl, head_q[sel_lvl]}),
		.rdata (rdata)
	);

	// Form the result from the running job or the entry just read
	always_comb begin
		out_pid     = disp_q ? rd_pid : run_pid_q;
		out_pid_ext = {{PID_W{1'b0}}, out_pid};
	end

	// Sequencer, level pointers and running job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			run_valid_q    <= 1'b0;
			run_pid_q      <= '0;
			run_lvl_q      <= '0;
			idle_quantum_q <= IDLE_QUANTUM_RST;
			full_q         <= 1'b0;
			disp_q         <= 1'b0;
			res_valid_q    <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				idle_quantum_q <= cfg_data;
			end
			// Raise on a new result, drop once the held one is taken
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (fire) begin
						full_q <= push_req && lvl_full;
						disp_q <= 1'b0;
						state_q <= cmd.timer ? ST_SEL : ST_RESP;
					end
					if (do_push) begin
						tail_q[push_lvl]  <= (tail_q[push_lvl] == IDX_W'(QUEUE_DEPTH - 1)) ?
							'0 : tail_q[push_lvl] + 1'b1;
						count_q[push_lvl] <= count_q[push_lvl] + 1'b1;
					end
				end
				ST_SEL: begin
					disp_q      <= any_ready;
					run_valid_q <= any_ready;
					run_lvl_q   <= any_ready ? sel_lvl : '0;
					run_pid_q   <= '0;
					if (any_ready) begin
						head_q[sel_lvl]  <= (head_q[sel_lvl] == IDX_W'(QUEUE_DEPTH - 1)) ?
							'0 : head_q[sel_lvl] + 1'b1;
						count_q[sel_lvl] <= count_q[sel_lvl] - 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (res_load) begin
						if (disp_q) begin
							run_pid_q <= rd_pid;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.run_pid     <= run_valid_q ? out_pid_ext[PID_W-1:0] : '0;
			res_q.run_is_idle <= !run_valid_q;
			res_q.run_pc      <= disp_q ? rd_pc : '0;
			res_q.quantum     <= run_valid_q ? level_square(PRIO_W'(run_lvl_q)) : idle_quantum_q;
			res_q.queue_full  <= full_q;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

[sv/multilevel_queue_dispatcher_unit.sv]
`timescale 1ns / 1ps
// A new-job item goes from enqueue to result load; a timer item also reads the ready store between them.
// The back end takes a new item only once the result of the last is loaded; its sequencer steps
// through enqueue, ready-store read and result load on the single RAM.
// A two-entry command queue keeps taking items while the back end or output stalls, until it is full.
// Reset is asynchronous and immediate: all levels empty, idle runs, idle quantum 2;
// the ready store needs no clearing pass.
// ----------------------------------------------------------------------------
// multilevel_queue_dispatcher_unit
// Multilevel queue dispatcher: per-level FIFOs of ready jobs, requeue on timer,
// dispatch of the head of the highest-priority nonempty level.
// ----------------------------------------------------------------------------
module multilevel_queue_dispatcher_unit import mlqd_pkg::*; #(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int PID_BITS    = PID_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// job_pid[7:0], job_priority[11:8], cur_halted[12], cur_pc[44:13], zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// func
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// run_pid[7:0], run_is_idle[8], run_pc[40:9], quantum[48:41], queue_full[49], zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [QUANT_W-1:0]     cfg_data
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;
	res_t res;

	mlqd_front #(
		.LEVELS (LEVELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd           (cmd),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready)
	);

	mlqd_back #(
		.LEVELS      (LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PID_BITS    (PID_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res       (res),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready)
	);

	assign cfg_ready = 1'b1;

	// Pack result fields, lowest field first
	assign m_axis_tdata = {6'b0, res.queue_full, res.quantum, res.run_pc,
		res.run_is_idle, res.run_pid};

endmodule

[sv/mlqd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqd_checker
// Port-level checks of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module mlqd_checker import mlqd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	logic [7:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Count items accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {7'b0, in_acc} - {7'b0, out_acc};
		end
	end

	// A result needs an item behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (pending_q != '0))
		else $error("result without a pending item");

	// Idle result carries no pid and no pc
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == '0 && m_axis_tdata[40:9] == '0))
		else $error("idle result with pid or pc");

	// Result holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped or changed while stalled");

	// Config port never blocks
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind multilevel_queue_dispatcher_unit mlqd_checker u_mlqd_checker (.*);

[test/dispatch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dispatch_checker
// Watches the job, result and idle-quantum channels of the multilevel queue
// dispatcher, keeps its own copy of the per-level ready queues and the running
// job, predicts each result item and compares it field by field.
// ----------------------------------------------------------------------------
module dispatch_checker import mlqd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// job_pid[7:0], job_priority[11:8], cur_halted[12], cur_pc[44:13], zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// func
	input  logic                   s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// run_pid[7:0], run_is_idle[8], run_pc[40:9], quantum[48:41], queue_full[49], zero pad
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [QUANT_W-1:0]     cfg_data,
	output int                     fail_count,
	output int                     pending
);

	localparam int LEVELS = LEVELS_DEF;
	localparam int QDEPTH = QUEUE_DEPTH_DEF;

	// Shadow of the ready queues
	logic [PID_W-1:0]   slot_pid [LEVELS][QDEPTH];
	logic [PC_W-1:0]    slot_pc  [LEVELS][QDEPTH];
	int unsigned        lvl_head [LEVELS];
	int unsigned        lvl_tail [LEVELS];
	int unsigned        lvl_count[LEVELS];

	// Shadow of the running job and the idle slice
	logic               run_valid;
	logic [PID_W-1:0]   run_job;
	logic [PRIO_W-1:0]  run_level;
	logic [QUANT_W-1:0] idle_slice;

	res_t expected_slices[$];
	int   mismatches;

	// Append a job to its level; return 0 when the level is full and the job is lost
	function automatic bit enqueue_job(input int unsigned lvl, input logic [PID_W-1:0] pid,
		input logic [PC_W-1:0] pc);
		int unsigned l;
		l = (lvl >= LEVELS) ? LEVELS - 1 : lvl;
		if (lvl_count[l] >= QDEPTH)
			return 1'b0;
		slot_pid[l][lvl_tail[l]] = pid;
		slot_pc[l][lvl_tail[l]]  = pc;
		lvl_tail[l] = (lvl_tail[l] + 1 >= QDEPTH) ? 0 : lvl_tail[l] + 1;
		lvl_count[l]++;
		return 1'b1;
	endfunction

	// Apply one job or timer item and work out the result it yields
	task automatic schedule_item(input logic timer, input logic [PRIO_W-1:0] level,
		input logic [PID_W-1:0] pid, input logic halted, input logic [PC_W-1:0] pc,
		output res_t r);
		logic              full;
		logic [PC_W-1:0]   restored;
		int unsigned       next_level;
		bit                found;
		full     = 1'b0;
		restored = '0;
		if (timer == FUNC_NEW_JOB) begin
			if (!enqueue_job(level, pid, '0))
				full = 1'b1;
		end else begin
			// requeue the preempted job one level down, wrapping to the top
			if (run_valid && !halted) begin
				next_level = run_level + 1;
				if (next_level >= LEVELS)
					next_level = 0;
				if (!enqueue_job(next_level, run_job, pc))
					full = 1'b1;
			end
			run_valid = 1'b0;
			run_job   = '0;
			run_level = '0;
			found     = 1'b0;
			// dispatch the head of the first nonempty level
			for (int l = 0; l < LEVELS; l++) begin
				if (!found && lvl_count[l] != 0) begin
					run_job   = slot_pid[l][lvl_head[l]];
					restored  = slot_pc[l][lvl_head[l]];
					run_level = PRIO_W'(l);
					run_valid = 1'b1;
					lvl_head[l] = (lvl_head[l] + 1 >= QDEPTH) ? 0 : lvl_head[l] + 1;
					lvl_count[l]--;
					found = 1'b1;
				end
			end
		end
		r.run_pid     = run_valid ? run_job : '0;
		r.run_is_idle = !run_valid;
		r.run_pc      = restored;
		r.quantum     = run_valid ? QUANT_W'(int'(run_level) * int'(run_level)) : idle_slice;
		r.queue_full  = full;
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Track handshakes: compare results first, then predict newly accepted items
	always @(posedge clk) begin
		res_t exp_r;
		res_t got_r;
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				lvl_head[l]  = 0;
				lvl_tail[l]  = 0;
				lvl_count[l] = 0;
			end
			run_valid  = 1'b0;
			run_job    = '0;
			run_level  = '0;
			idle_slice = IDLE_QUANTUM_RST;
			expected_slices.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_r.run_pid     = m_axis_tdata[7:0];
				got_r.run_is_idle = m_axis_tdata[8];
				got_r.run_pc      = m_axis_tdata[40:9];
				got_r.quantum     = m_axis_tdata[48:41];
				got_r.queue_full  = m_axis_tdata[49];
				if (expected_slices.size() == 0) begin
					$display("%0t ns: result item with none expected, expected none, actual %0h",
						$time, m_axis_tdata);
					mismatches++;
				end else begin
					exp_r = expected_slices.pop_front();
					check_field("run_pid", 64'(exp_r.run_pid), 64'(got_r.run_pid));
					check_field("run_is_idle", 64'(exp_r.run_is_idle), 64'(got_r.run_is_idle));
					check_field("run_pc", 64'(exp_r.run_pc), 64'(got_r.run_pc));
					check_field("quantum", 64'(exp_r.quantum), 64'(got_r.quantum));
					check_field("queue_full", 64'(exp_r.queue_full), 64'(got_r.queue_full));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				schedule_item(s_axis_tuser, s_axis_tdata[11:8], s_axis_tdata[7:0],
					s_axis_tdata[12], s_axis_tdata[44:13], exp_r);
				expected_slices.push_back(exp_r);
			end
			if (cfg_valid && cfg_ready)
				idle_slice = cfg_data;
		end
		fail_count <= mismatches;
		pending    <= expected_slices.size();
	end

endmodule

[test/multilevel_queue_dispatcher_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_dispatcher_unit_tb
// Drives job and timer items into the dispatcher: a directed opening over the
// field extremes and special cases, then bursts that fill levels, chain timer
// preemptions and drain to idle, under three sender/receiver stall mixes and
// several idle quantum settings. The checker beside the block scores results.
// ----------------------------------------------------------------------------
module multilevel_queue_dispatcher_unit_tb;
	import mlqd_pkg::*;

	localparam int MAX_CYCLES = 200000;
	localparam int SETTLE     = 12;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [QUANT_W-1:0]     cfg_data;

	int fail_count;
	int pending;
	int tx_idle_pct;
	int rx_idle_pct;
	int cycle_count;

	multilevel_queue_dispatcher_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	dispatch_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Stall the result channel at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Give up after a generous number of cycles
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one item after a random gap and hold it until accepted
	task automatic send_item(input logic func, input logic [PID_W-1:0] pid,
		input logic [PRIO_W-1:0] pri, input logic halted, input logic [PC_W-1:0] pc);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= IN_TDATA_W'({pc, halted, pri, pid});
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold off the sender until every expected result has come
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_idle_quantum(input logic [QUANT_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random workload: level fills, preemption chains, drains to idle and noise
	task automatic random_workload(input int count);
		int sent;
		int kind;
		int len;
		logic [PRIO_W-1:0] lvl;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(9);
			if (kind <= 2) begin
				// pile jobs onto one level, often past its depth
				lvl = PRIO_W'($urandom_range(15));
				len = $urandom_range(1, 40);
				for (int i = 0; i < len; i++) begin
					send_item(FUNC_NEW_JOB, PID_W'($urandom), lvl, 1'($urandom),
						$urandom);
				end
			end else if (kind <= 6) begin
				// preempt repeatedly, mostly without termination
				len = $urandom_range(1, 20);
				for (int i = 0; i < len; i++) begin
					send_item(FUNC_TIMER, PID_W'($urandom), PRIO_W'($urandom),
						($urandom_range(9) < 2), $urandom);
				end
			end else if (kind == 7) begin
				// terminate jobs until the levels run dry
				len = $urandom_range(1, 60);
				for (int i = 0; i < len; i++) begin
					send_item(FUNC_TIMER, PID_W'($urandom), PRIO_W'($urandom),
						($urandom_range(9) != 0), $urandom);
				end
			end else begin
				len = 1;
				send_item(1'($urandom), PID_W'($urandom), PRIO_W'($urandom),
					1'($urandom), $urandom);
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_NEW_JOB;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		tx_idle_pct   = 36;
		rx_idle_pct   = 76;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, reset idle quantum still in force
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b1, 32'hFFFF_FFFF);
		send_item(FUNC_TIMER,   8'hFF, 4'd15, 1'b0, 32'h0000_0001);
		send_item(FUNC_NEW_JOB, 8'hFF, 4'd0,  1'b1, 32'hFFFF_FFFF);
		send_item(FUNC_NEW_JOB, 8'h00, 4'd14, 1'b0, 32'h0000_0000);
		send_item(FUNC_NEW_JOB, 8'h5A, 4'd15, 1'b1, 32'hA5A5_A5A5);
		send_item(FUNC_NEW_JOB, 8'hA5, 4'd7,  1'b0, 32'h5A5A_5A5A);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b0, 32'hDEAD_BEEF);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b0, 32'hFFFF_FFFF);
		send_item(FUNC_NEW_JOB, 8'h81, 4'd1,  1'b0, 32'h0);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b1, 32'h0);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b0, 32'h1234_5678);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b1, 32'h0);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b0, 32'h8000_0000);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b1, 32'h0);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b1, 32'h0);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b1, 32'h0);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b0, 32'hFFFF_FFFF);
		send_item(FUNC_NEW_JOB, 8'h3C, 4'd14, 1'b0, 32'h0);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b0, 32'h0000_FFFF);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b0, 32'hFFFF_0000);
		send_item(FUNC_TIMER,   8'h00, 4'd0,  1'b1, 32'h0);

		// Sender idles lightly, receiver heavily
		write_idle_quantum(8'd0);
		random_workload(270);

		// Sender idles heavily, receiver lightly
		write_idle_quantum(8'd255);
		tx_idle_pct = 76;
		rx_idle_pct = 36;
		random_workload(270);

		// Back to back on both sides
		write_idle_quantum(QUANT_W'($urandom_range(1, 254)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_workload(270);

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
